[src/psg_register_file_tone_picker_top_defines.svh]
// Assertion macros shared by the sound register file RTL.
`ifndef PSG_REGISTER_FILE_TONE_PICKER_TOP_DEFINES_SVH
`define PSG_REGISTER_FILE_TONE_PICKER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define PSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define PSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/psg_rftp_pkg.sv]
package psg_rftp_pkg;

  localparam int CMD_W   = 2;
  localparam int DATA_W  = 8;
  localparam int FREQ_W  = 20;
  localparam int AMP_W   = 6;
  localparam int CLK_W   = 24;
  localparam int IDX_W   = 4;
  localparam int NREG    = 16;
  localparam int NCH     = 3;
  localparam int PER_W   = 12;
  localparam int LVL_W   = 4;
  localparam int NPER_W  = 5;
  localparam int MIX_W   = 6;

  localparam logic [CLK_W-1:0] CLOCK_HZ_RESET = 24'd2000000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SELECT   = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_READ_REG = 2'd2,
    CMD_READ_IDX = 2'd3
  } cmd_t;

  // Register map boundaries
  localparam logic [IDX_W-1:0] REG_TONE_A_FINE   = 4'd0;
  localparam logic [IDX_W-1:0] REG_TONE_A_COARSE = 4'd1;
  localparam logic [IDX_W-1:0] REG_TONE_C_FINE   = 4'd4;
  localparam logic [IDX_W-1:0] REG_TONE_LAST = 4'd5;
  localparam logic [IDX_W-1:0] REG_NOISE_PER = 4'd6;
  localparam logic [IDX_W-1:0] REG_MIXER     = 4'd7;
  localparam logic [IDX_W-1:0] REG_AMP_A     = 4'd8;
  localparam logic [IDX_W-1:0] REG_AMP_LAST  = 4'd10;
  localparam logic [IDX_W-1:0] REG_ENV_LAST  = 4'd12;
  localparam logic [IDX_W-1:0] REG_LAST      = 4'd15;

  // Bit 4 of an amplitude register selects envelope mode
  localparam int AMP_MODE_BIT = 4;

endpackage

[src/psg_rftp_if.sv]
interface psg_rftp_in_if
  import psg_rftp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [DATA_W-1:0] data;

  modport source (output valid, output command, output data, input ready);
  modport sink (input valid, input command, input data, output ready);
endinterface

interface psg_rftp_out_if
  import psg_rftp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              sound_update;
  logic [FREQ_W-1:0] tone_freq;
  logic [AMP_W-1:0]  tone_amp;
  logic [FREQ_W-1:0] noise_freq;
  logic [AMP_W-1:0]  noise_amp;

  modport source (
    output valid, output read_data, output sound_update, output tone_freq,
    output tone_amp, output noise_freq, output noise_amp, input ready
  );
  modport sink (
    input valid, input read_data, input sound_update, input tone_freq,
    input tone_amp, input noise_freq, input noise_amp, output ready
  );
endinterface

[src/psg_register_file_tone_picker_top.sv]
// Result: select, read, unchanged writes and writes to registers 13-15 load the output
//   register from the transfer; mixer, amplitude, envelope, zero-period writes use ST_PICK.
// Nonzero period writes (registers 0-6) run ST_DIV, one restoring divider step per
//   cycle for the 20 quotient bits, then ST_PICK to pick the loudest channels.
// Throughput: one command at a time; a new transfer waits for the sequencer to idle.
// Reset (rst_n, synchronous, low): clears registers, derived state, index, output; clock 2 MHz.
`include "psg_register_file_tone_picker_top_defines.svh"

module psg_register_file_tone_picker_top
  import psg_rftp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CLK_W-1:0] cfg_wr_data,
  psg_rftp_in_if.sink      in_ch,
  psg_rftp_out_if.source   out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_PICK = 3'b100
  } state_t;

  // Divider destination: tone channel A..C or the noise generator
  localparam logic [1:0] TGT_NOISE = 2'd3;

  localparam int DIV_STEPS = FREQ_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // Chip state
  logic [CLK_W-1:0]  clock_hz_r;
  logic [DATA_W-1:0] reg_file_r [NREG];
  logic [IDX_W-1:0]  reg_index_r;
  logic [PER_W-1:0]  tone_per_r [NCH];
  logic [FREQ_W-1:0] tone_freq_r [NCH];
  logic [FREQ_W-1:0] noise_freq_r;
  logic [MIX_W-1:0]  mixer_r;
  logic [LVL_W-1:0]  amp_r [NCH];

  // Sequencer and shared divider
  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        tgt_r;
  logic [PER_W-1:0]  den_r;
  logic [PER_W-1:0]  rem_r;
  logic [FREQ_W-1:0] quo_r;
  logic [PER_W-1:0]  rem_nxt;
  logic [FREQ_W-1:0] quo_nxt;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_data_r;
  logic              out_update_r;
  logic [FREQ_W-1:0] out_tone_freq_r;
  logic [AMP_W-1:0]  out_tone_amp_r;
  logic [FREQ_W-1:0] out_noise_freq_r;
  logic [AMP_W-1:0]  out_noise_amp_r;

  logic              in_ready;
  logic              in_fire;
  cmd_t              cmd;
  logic [IDX_W-1:0]  wr_idx;
  logic [1:0]        wr_ch;
  logic [PER_W-1:0]  wr_period;
  logic              wr_same;
  logic              wr_refresh;

  logic [FREQ_W-1:0] pick_tone_f;
  logic [LVL_W-1:0]  pick_tone_a;
  logic [LVL_W-1:0]  pick_noise_a;

  logic              out_plain;
  logic              out_sound_zero;

  // Accept only when idle and the output register is free (or draining now)
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign cmd     = cmd_t'(in_ch.command);
  assign wr_idx  = reg_index_r;
  assign wr_ch   = wr_idx[2:1];
  assign wr_same = (reg_file_r[wr_idx] == in_ch.data);

  // A changed write to registers 0..12 defers its result to the pick step
  assign wr_refresh = (cmd == CMD_WRITE) && !wr_same && (wr_idx <= REG_ENV_LAST);

  // New period seen by the divider for a write to registers 0..6
  always_comb begin
    if (wr_idx == REG_NOISE_PER) begin
      wr_period = PER_W'(in_ch.data[NPER_W-1:0]);
    end else if (wr_idx[0]) begin
      wr_period = {in_ch.data[PER_W-DATA_W-1:0], tone_per_r[wr_ch][DATA_W-1:0]};
    end else begin
      wr_period = {tone_per_r[wr_ch][PER_W-1:DATA_W], in_ch.data};
    end
  end

  // One restoring divide step: shift in the next dividend bit, trial subtract
  logic [PER_W:0] rem_sh;
  logic           rem_ge;
  always_comb begin
    rem_sh  = {rem_r, quo_r[FREQ_W-1]};
    rem_ge  = (rem_sh >= {1'b0, den_r});
    rem_nxt = rem_ge ? PER_W'(rem_sh - {1'b0, den_r}) : rem_sh[PER_W-1:0];
    quo_nxt = {quo_r[FREQ_W-2:0], rem_ge};
  end

  // Loudest enabled tone channel (first strictly louder wins), loudest noise level
  always_comb begin
    pick_tone_f  = '0;
    pick_tone_a  = '0;
    pick_noise_a = '0;
    for (int ch = 0; ch < NCH; ch++) begin
      if (mixer_r[ch] && (amp_r[ch] > pick_tone_a)) begin
        pick_tone_f = tone_freq_r[ch];
        pick_tone_a = amp_r[ch];
      end
      if (mixer_r[ch + NCH] && (amp_r[ch] > pick_noise_a)) begin
        pick_noise_a = amp_r[ch];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r   <= CLOCK_HZ_RESET;
      reg_index_r  <= '0;
      noise_freq_r <= '0;
      mixer_r      <= '0;
      for (int i = 0; i < NREG; i++) begin
        reg_file_r[i] <= '0;
      end
      for (int i = 0; i < NCH; i++) begin
        tone_per_r[i]  <= '0;
        tone_freq_r[i] <= '0;
        amp_r[i]       <= '0;
      end
      state_r          <= ST_IDLE;
      cnt_r            <= '0;
      tgt_r            <= '0;
      den_r            <= '0;
      rem_r            <= '0;
      quo_r            <= '0;
      out_valid_r      <= 1'b0;
      out_read_data_r  <= '0;
      out_update_r     <= 1'b0;
      out_tone_freq_r  <= '0;
      out_tone_amp_r   <= '0;
      out_noise_freq_r <= '0;
      out_noise_amp_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        clock_hz_r <= cfg_wr_data;
      end
      // Drop the result once the sink takes it, unless a new command refills it
      if (out_valid_r && out_ch.ready && !in_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            // Default: a plain result with no sound refresh; a refresh holds it back
            out_read_data_r  <= '0;
            out_update_r     <= 1'b0;
            out_tone_freq_r  <= '0;
            out_tone_amp_r   <= '0;
            out_noise_freq_r <= '0;
            out_noise_amp_r  <= '0;
            out_valid_r      <= !wr_refresh;
            unique case (cmd)
              CMD_SELECT: begin
                reg_index_r <= in_ch.data[IDX_W-1:0];
              end
              CMD_READ_REG: begin
                out_read_data_r <= reg_file_r[reg_index_r];
              end
              CMD_READ_IDX: begin
                out_read_data_r <= DATA_W'(reg_index_r);
              end
              CMD_WRITE: begin
                if (!wr_same) begin
                  reg_file_r[wr_idx] <= in_ch.data;
                  if (wr_idx <= REG_NOISE_PER) begin
                    // Period write: hold the result until the divider finishes
                    if (wr_idx != REG_NOISE_PER) begin
                      tone_per_r[wr_ch] <= wr_period;
                    end
                    tgt_r <= (wr_idx == REG_NOISE_PER) ? TGT_NOISE : wr_ch;
                    if (wr_period == '0) begin
                      // Zero period gives zero frequency, no divide
                      if (wr_idx == REG_NOISE_PER) begin
                        noise_freq_r <= '0;
                      end else begin
                        tone_freq_r[wr_ch] <= '0;
                      end
                      state_r <= ST_PICK;
                    end else begin
                      den_r   <= wr_period;
                      rem_r   <= '0;
                      quo_r   <= clock_hz_r[CLK_W-1:4];
                      cnt_r   <= '0;
                      state_r <= ST_DIV;
                    end
                  end else if (wr_idx == REG_MIXER) begin
                    mixer_r <= ~in_ch.data[MIX_W-1:0];
                    state_r <= ST_PICK;
                  end else if (wr_idx <= REG_AMP_LAST) begin
                    amp_r[2'(wr_idx - REG_AMP_A)] <=
                      in_ch.data[AMP_MODE_BIT] ? '0 : in_ch.data[LVL_W-1:0];
                    state_r <= ST_PICK;
                  end else if (wr_idx <= REG_ENV_LAST) begin
                    state_r <= ST_PICK;
                  end
                end
              end
              default: begin
                reg_index_r <= reg_index_r;
              end
            endcase
          end
        end
        ST_DIV: begin
          // Advance one quotient bit a cycle
          rem_r <= rem_nxt;
          quo_r <= quo_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            if (tgt_r == TGT_NOISE) begin
              noise_freq_r <= quo_nxt;
            end else begin
              tone_freq_r[tgt_r] <= quo_nxt;
            end
            state_r <= ST_PICK;
          end
        end
        ST_PICK: begin
          out_valid_r      <= 1'b1;
          out_read_data_r  <= '0;
          out_update_r     <= 1'b1;
          out_tone_freq_r  <= pick_tone_f;
          out_tone_amp_r   <= {pick_tone_a, 2'b00};
          out_noise_freq_r <= (pick_noise_a != '0) ? noise_freq_r : '0;
          out_noise_amp_r  <= {pick_noise_a, 2'b00};
          state_r          <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = out_read_data_r;
  assign out_ch.sound_update = out_update_r;
  assign out_ch.tone_freq    = out_tone_freq_r;
  assign out_ch.tone_amp     = out_tone_amp_r;
  assign out_ch.noise_freq   = out_noise_freq_r;
  assign out_ch.noise_amp    = out_noise_amp_r;

  assign out_plain      = out_valid_r && !out_update_r;
  assign out_sound_zero = (out_tone_freq_r == '0) && (out_tone_amp_r == '0) &&
                          (out_noise_freq_r == '0) && (out_noise_amp_r == '0);

  `PSG_ASSERT_NOW(a_busy_out_empty, state_r != ST_IDLE, !out_valid_r, "result held while busy")
  `PSG_ASSERT_NEXT(a_pick_delivers, state_r == ST_PICK, out_valid_r && out_update_r, "pick lost")
  `PSG_ASSERT_NEXT(a_plain_cmd_result, in_fire && (cmd != CMD_WRITE), out_plain, "no plain result")
  `PSG_ASSERT_NOW(a_no_update_zero, out_plain, out_sound_zero, "sound fields set without update")
  `PSG_ASSERT_NOW(a_div_nonzero, state_r == ST_DIV, den_r != '0, "divide by zero period")

endmodule

[bench/psg_rftp_checker.sv]
`timescale 1ns / 100ps

module psg_rftp_checker
  import psg_rftp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CLK_W-1:0] cfg_wr_data,
  psg_rftp_in_if           in_mon,
  psg_rftp_out_if          out_mon,
  output int unsigned      outstanding,
  output int unsigned      failures
);

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              sound_update;
    logic [FREQ_W-1:0] tone_freq;
    logic [AMP_W-1:0]  tone_amp;
    logic [FREQ_W-1:0] noise_freq;
    logic [AMP_W-1:0]  noise_amp;
  } bus_reply_t;

  // Shadow of the sound chip state
  logic [DATA_W-1:0] regs [NREG];
  logic [IDX_W-1:0]  sel_idx;
  logic [FREQ_W-1:0] tone_hz [NCH];
  logic [FREQ_W-1:0] noise_hz;
  logic [MIX_W-1:0]  mix_en;
  logic [LVL_W-1:0]  level [NCH];
  logic [CLK_W-1:0]  chip_clock;
  bus_reply_t        replies_due [$];

  // (chip clock / 16) / period, zero period gives zero
  function automatic logic [FREQ_W-1:0] clock_over(int unsigned period);
    int unsigned base;
    base = chip_clock;
    if (period == 0) return '0;
    return FREQ_W'((base / 16) / period);
  endfunction

  function automatic bus_reply_t apply_command(logic [CMD_W-1:0] cmd_bits,
                                               logic [DATA_W-1:0] payload);
    bus_reply_t       r;
    logic [LVL_W-1:0] best;
    int unsigned      ch;
    r = '0;
    case (cmd_t'(cmd_bits))
      CMD_SELECT:   sel_idx = payload[IDX_W-1:0];
      CMD_READ_REG: r.read_data = regs[sel_idx];
      CMD_READ_IDX: r.read_data = DATA_W'(sel_idx);
      CMD_WRITE: begin
        if (regs[sel_idx] != payload) begin
          regs[sel_idx] = payload;
          if (sel_idx <= REG_TONE_LAST) begin
            ch = sel_idx >> 1;
            tone_hz[ch] = clock_over({regs[2*ch+1][3:0], regs[2*ch]});
          end else if (sel_idx == REG_NOISE_PER) begin
            noise_hz = clock_over(payload[NPER_W-1:0]);
          end else if (sel_idx == REG_MIXER) begin
            mix_en = ~payload[MIX_W-1:0];
          end else if (sel_idx <= REG_AMP_LAST) begin
            level[sel_idx - REG_AMP_A] = payload[AMP_MODE_BIT] ? '0 : payload[LVL_W-1:0];
          end
          r.sound_update = (sel_idx <= REG_ENV_LAST);
          if (r.sound_update) begin
            // first strictly louder channel wins, silent channels never do
            best = '0;
            for (ch = 0; ch < NCH; ch++) begin
              if (mix_en[ch] && level[ch] > best) begin
                r.tone_freq = tone_hz[ch];
                best = level[ch];
              end
            end
            r.tone_amp = {best, 2'b00};
            best = '0;
            for (ch = 0; ch < NCH; ch++) begin
              if (mix_en[ch+NCH] && level[ch] > best) begin
                r.noise_freq = noise_hz;
                best = level[ch];
              end
            end
            r.noise_amp = {best, 2'b00};
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic [FREQ_W-1:0] want, logic [FREQ_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin : watch
    bus_reply_t want;
    int         i;
    if (!rst_n) begin
      for (i = 0; i < NREG; i++) regs[i] = '0;
      for (i = 0; i < NCH; i++) begin
        tone_hz[i] = '0;
        level[i]   = '0;
      end
      sel_idx    = '0;
      noise_hz   = '0;
      mix_en     = '0;
      chip_clock = CLOCK_HZ_RESET;
      replies_due.delete();
    end else begin
      if (cfg_wr_en) chip_clock = cfg_wr_data;
      if (out_mon.valid && out_mon.ready) begin
        if (replies_due.size() == 0) begin
          $error("result transfer with no command waiting");
          failures++;
        end else begin
          want = replies_due.pop_front();
          check_field("read_data", want.read_data, out_mon.read_data);
          check_field("sound_update", want.sound_update, out_mon.sound_update);
          check_field("tone_freq", want.tone_freq, out_mon.tone_freq);
          check_field("tone_amp", want.tone_amp, out_mon.tone_amp);
          check_field("noise_freq", want.noise_freq, out_mon.noise_freq);
          check_field("noise_amp", want.noise_amp, out_mon.noise_amp);
        end
      end
      if (in_mon.valid && in_mon.ready)
        replies_due.push_back(apply_command(in_mon.command, in_mon.data));
    end
    outstanding = replies_due.size();
  end

endmodule

[bench/tb_psg_register_file_tone_picker_top.sv]
`timescale 1ns / 100ps

module tb_psg_register_file_tone_picker_top;
  import psg_rftp_pkg::*;

  localparam int NUM_PHASES     = 9;
  localparam int PHASE_ITEMS    = 140;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 40;

  // Chip clocks for phases 1..7; the last phase draws its own
  localparam logic [CLK_W-1:0] CLOCK_PLAN [7] = '{
    24'hFFFFFF, 24'd0, 24'd16, 24'd15, 24'd17, 24'd1000000, 24'd2000000
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CLK_W-1:0] cfg_wr_data;
  int unsigned      outstanding;
  int unsigned      failures;
  int unsigned      items_sent;
  int unsigned      send_run;
  int unsigned      recv_run;
  int unsigned      quiet_cycles;

  psg_rftp_in_if  in_ch ();
  psg_rftp_out_if out_ch ();

  psg_register_file_tone_picker_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  psg_rftp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .outstanding (outstanding),
    .failures    (failures)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Draw the idle cycles before the next transfer. Now and then start a run
  // of back-to-back transfers so both the busy and the gapless cases occur.
  function automatic int unsigned draw_gap(inout int unsigned run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) begin
      run_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Present one bus command and hold it until the block takes it. Valid is
  // only lowered when a gap is drawn, so back-to-back commands never see a
  // low and a high scheduled in the same step.
  task automatic send_command(cmd_t cmd, logic [DATA_W-1:0] payload);
    int unsigned gap;
    gap = draw_gap(send_run);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.command <= cmd;
    in_ch.data    <= payload;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid and hold off until every predicted reply has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Single-cycle pulse on the clock register write port.
  task automatic write_clock(logic [CLK_W-1:0] hz);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // One random snippet of bus traffic. Most of it is select-then-write, the
  // way a driver talks to the chip, so derived state keeps moving; the rest
  // is read-back, repeated bytes and loose commands.
  task automatic play_random_command();
    int unsigned       pick;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] byte_val;
    pick = $urandom_range(0, 99);
    // mostly sound registers, sometimes the three with no refresh
    idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(REG_ENV_LAST + 1, REG_LAST))
                                      : IDX_W'($urandom_range(REG_TONE_A_FINE, REG_ENV_LAST));
    // small bytes make zero and unit periods, mixer-all-on and level ties
    byte_val = ($urandom_range(0, 3) == 0) ? DATA_W'($urandom_range(0, 3))
                                           : DATA_W'($urandom);
    if (pick < 50) begin
      send_command(CMD_SELECT, {IDX_W'($urandom), idx});
      send_command(CMD_WRITE, byte_val);
    end else if (pick < 60) begin
      // second write of the same byte leaves everything unchanged
      send_command(CMD_SELECT, {IDX_W'($urandom), idx});
      send_command(CMD_WRITE, byte_val);
      send_command(CMD_WRITE, byte_val);
    end else if (pick < 80) begin
      send_command(CMD_SELECT, {IDX_W'($urandom), idx});
      send_command(CMD_READ_REG, DATA_W'($urandom));
    end else begin
      send_command(cmd_t'($urandom_range(0, 3)), DATA_W'($urandom));
    end
  endtask

  // Result side: stall a drawn number of cycles, then accept one transfer.
  initial begin : result_sink
    int unsigned gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = draw_gap(recv_run);
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      phase;
    int unsigned      phase_start;
    logic [CLK_W-1:0] hz;

    // Known values on every input before the first edge
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_SELECT;
    in_ch.data    = '0;
    items_sent    = 0;
    send_run      = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reads right after reset, then walk the register map at the
    // default chip clock.
    send_command(CMD_READ_IDX, 8'hFF);
    send_command(CMD_READ_REG, 8'h00);
    // high nibble of a select is ignored
    send_command(CMD_SELECT, 8'hF0 | 8'(REG_MIXER));
    // unchanged write: mixer byte is already zero, nothing refreshes
    send_command(CMD_WRITE, 8'h00);
    // enable every tone and noise; port direction bits are stored only
    send_command(CMD_WRITE, 8'hC0);
    send_command(CMD_SELECT, 8'(REG_AMP_A));
    send_command(CMD_WRITE, 8'h0F);
    // mode bit silences channel B
    send_command(CMD_SELECT, 8'(REG_AMP_A) + 8'd1);
    send_command(CMD_WRITE, 8'h1F);
    // channel C ties channel A at full level, A must keep winning
    send_command(CMD_SELECT, 8'(REG_AMP_LAST));
    send_command(CMD_WRITE, 8'h0F);
    // coarse then fine tone period of channel A, up to the largest period
    send_command(CMD_SELECT, 8'(REG_TONE_A_COARSE));
    send_command(CMD_WRITE, 8'hFF);
    send_command(CMD_SELECT, 8'(REG_TONE_A_FINE));
    send_command(CMD_WRITE, 8'hFF);
    // period one on channel C gives the highest frequency
    send_command(CMD_SELECT, 8'(REG_TONE_C_FINE));
    send_command(CMD_WRITE, 8'h01);
    // noise period uses five bits only
    send_command(CMD_SELECT, 8'(REG_NOISE_PER));
    send_command(CMD_WRITE, 8'hFF);
    // envelope shape register refreshes with no rate of its own
    send_command(CMD_SELECT, 8'(REG_ENV_LAST));
    send_command(CMD_WRITE, 8'h80);
    // register past the envelope block is stored with no refresh
    send_command(CMD_SELECT, 8'(REG_ENV_LAST) + 8'd1);
    send_command(CMD_WRITE, 8'h5A);
    send_command(CMD_READ_REG, 8'hA5);
    send_command(CMD_READ_IDX, 8'h00);

    // Random phases. Each later phase first drains, then moves the chip
    // clock; frequencies derived earlier keep their old value.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_for_drain();
        hz = (phase <= 7) ? CLOCK_PLAN[phase-1] : CLK_W'($urandom);
        write_clock(hz);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        // occasionally let the block run completely dry mid-phase
        if ($urandom_range(0, 99) == 0) wait_for_drain();
        play_random_command();
      end
    end

    // Wind down: every reply back, then a quiet tail to catch strays.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
